### rtl/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared types and constants for the vector normalizer.
// ----------------------------------------------------------------------------
package v3n_pkg;

    localparam int unsigned RootSteps = 32;
    localparam int unsigned QuotBits  = 31;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_v3n_in;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic        [31:0] magnitude;
        logic               zero_length;
    } t_v3n_out;

endpackage

### rtl/vector3_normalize_top.sv
// ----------------------------------------------------------------------------
// vector3_normalize_top
// Pipelined 3D vector normalizer, Q16.16 in, Q2.30 unit vector out.
// ----------------------------------------------------------------------------
// Usage: drive i_in and raise start; the vector transfers at a rising edge
// where start is high and busy is low. busy is always low, so a new
// vector may transfer in every cycle.
// Stage 1 squares the three components and stage 2 sums them. The square
// root runs as 32 register stages, one result bit per stage. The three
// divisions then run in lockstep, 31 restoring stages of one quotient bit
// each, and a final stage restores the signs and registers the result.
// o_done is registered together with o_out in the final stage; throughput is
// one vector per cycle, set by the bit-per-stage root and divider pipelines.
// o_done is high for exactly one cycle with o_out; the receiver cannot stall
// the block, and the pipeline never holds.
// Reset clears all valid bits; vectors in flight are dropped.
// A zero vector yields zero components, zero magnitude and zero_length set.
// ----------------------------------------------------------------------------
module vector3_normalize_top
    import v3n_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_v3n_in  i_in,
    output logic     o_done,
    output t_v3n_out o_out
);

    assign busy = 1'b0;

    // stage 1: absolute values and squares
    logic               r_v1;
    logic        [63:0] r_sq [3];
    logic        [31:0] r_a1 [3];
    logic        [2:0]  r_s1;

    logic [31:0] n_abs [3];
    logic [2:0]  n_sgn;
    always_comb begin
        n_sgn = {i_in.in_z[31], i_in.in_y[31], i_in.in_x[31]};
        n_abs[0] = n_sgn[0] ? 32'(-i_in.in_x) : 32'(i_in.in_x);
        n_abs[1] = n_sgn[1] ? 32'(-i_in.in_y) : 32'(i_in.in_y);
        n_abs[2] = n_sgn[2] ? 32'(-i_in.in_z) : 32'(i_in.in_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        for (int k = 0; k < 3; k++) begin
            r_sq[k] <= 64'(n_abs[k]) * 64'(n_abs[k]);
            r_a1[k] <= n_abs[k];
        end
        r_s1 <= n_sgn;
    end

    // stage 2: sum of squares
    logic        r_v2;
    logic [63:0] r_sum;
    logic [31:0] r_a2 [3];
    logic [2:0]  r_s2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        r_a2  <= r_a1;
        r_s2  <= r_s1;
    end

    // square root: one bit per stage
    logic        r_rv  [RootSteps+1];
    logic [65:0] r_rem [RootSteps+1];
    logic [63:0] r_rad [RootSteps+1];
    logic [31:0] r_rt  [RootSteps+1];
    logic [31:0] r_ra  [RootSteps+1][3];
    logic [2:0]  r_rs  [RootSteps+1];

    always_comb begin
        r_rv[0]  = r_v2;
        r_rem[0] = '0;
        r_rad[0] = r_sum;
        r_rt[0]  = '0;
        r_ra[0]  = r_a2;
        r_rs[0]  = r_s2;
    end

    for (genvar g = 0; g < RootSteps; g++) begin : g_root
        logic [65:0] n_rem;
        logic [65:0] n_try;
        always_comb begin
            n_rem = {r_rem[g][63:0], r_rad[g][63:62]};
            n_try = n_rem - {32'd0, r_rt[g], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[g+1] <= 1'b0;
            end else begin
                r_rv[g+1] <= r_rv[g];
            end
            r_rad[g+1] <= {r_rad[g][61:0], 2'b00};
            if (!n_try[65]) begin
                r_rem[g+1] <= n_try;
                r_rt[g+1]  <= {r_rt[g][30:0], 1'b1};
            end else begin
                r_rem[g+1] <= n_rem;
                r_rt[g+1]  <= {r_rt[g][30:0], 1'b0};
            end
            r_ra[g+1] <= r_ra[g];
            r_rs[g+1] <= r_rs[g];
        end
    end

    // division: a<<30 / mag, quotient < 2^31, one bit per stage
    // a>>1 < mag, so the remainder starts at a>>1 and the low 31 numerator
    // bits {a[0], 30'd0} shift in
    logic        r_dv  [QuotBits+1];
    logic [31:0] r_mag [QuotBits+1];
    logic [32:0] r_rm  [QuotBits+1][3];
    logic [30:0] r_num [QuotBits+1][3];
    logic [30:0] r_q   [QuotBits+1][3];
    logic [2:0]  r_ds  [QuotBits+1];

    always_comb begin
        r_dv[0]  = r_rv[RootSteps];
        r_mag[0] = r_rt[RootSteps];
        r_ds[0]  = r_rs[RootSteps];
        for (int k = 0; k < 3; k++) begin
            r_rm[0][k]  = {2'b00, r_ra[RootSteps][k][31:1]};
            r_num[0][k] = {r_ra[RootSteps][k][0], 30'd0};
            r_q[0][k]   = '0;
        end
    end

    for (genvar g = 0; g < QuotBits; g++) begin : g_div
        logic [32:0] n_sh [3];
        logic [33:0] n_df [3];
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                n_sh[k] = {r_rm[g][k][31:0], r_num[g][k][30]};
                n_df[k] = {1'b0, n_sh[k]} - {2'b00, r_mag[g]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g+1] <= 1'b0;
            end else begin
                r_dv[g+1] <= r_dv[g];
            end
            r_mag[g+1] <= r_mag[g];
            r_ds[g+1]  <= r_ds[g];
            for (int k = 0; k < 3; k++) begin
                r_num[g+1][k] <= {r_num[g][k][29:0], 1'b0};
                if (!n_df[k][33]) begin
                    r_rm[g+1][k] <= n_df[k][32:0];
                    r_q[g+1][k]  <= {r_q[g][k][29:0], 1'b1};
                end else begin
                    r_rm[g+1][k] <= n_sh[k];
                    r_q[g+1][k]  <= {r_q[g][k][29:0], 1'b0};
                end
            end
        end
    end

    // output stage: signs and zero case
    logic        [31:0] n_u [3];
    logic               n_z;
    always_comb begin
        n_z = (r_mag[QuotBits] == 32'd0);
        for (int k = 0; k < 3; k++) begin
            n_u[k] = r_ds[QuotBits][k] ? 32'(-{1'b0, r_q[QuotBits][k]})
                                       : {1'b0, r_q[QuotBits][k]};
            if (n_z) begin
                n_u[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_dv[QuotBits];
        end
        o_out.unit_x      <= n_u[0];
        o_out.unit_y      <= n_u[1];
        o_out.unit_z      <= n_u[2];
        o_out.magnitude   <= r_mag[QuotBits];
        o_out.zero_length <= n_z;
    end

endmodule

### rtl/v3n_checker.sv
// ----------------------------------------------------------------------------
// v3n_checker
// Port-level assertions for the vector normalizer.
// ----------------------------------------------------------------------------
module v3n_checker
    import v3n_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     busy,
    input logic     o_done,
    input t_v3n_out o_out
);

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out.zero_length |-> o_out.magnitude == 32'd0
            && o_out.unit_x == 32'sd0 && o_out.unit_y == 32'sd0
            && o_out.unit_z == 32'sd0)
        else $error("zero flag with nonzero payload");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_out.zero_length |-> o_out.magnitude != 32'd0)
        else $error("zero magnitude without flag");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.unit_x <= 32'sh4000_0000 && o_out.unit_x >= -32'sh4000_0000))
        else $error("unit_x out of range");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_no_spurious: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("done right after reset");

endmodule

bind vector3_normalize_top v3n_checker u_v3n_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_done  (o_done),
    .o_out   (o_out)
);
